// ===== design/tile_average_pixelate_defines.svh =====
// assertion macros for the tile averaging block
// expects signals named clk and rst in the scope where a macro is used
`ifndef TILE_AVERAGE_PIXELATE_DEFINES_SVH
`define TILE_AVERAGE_PIXELATE_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define TAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define TAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tap_pkg.sv =====
// shared types, constants and helpers of the tile averaging block
// no dependencies
`default_nettype none

package tap_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int MAX_TILE  = 64;

  localparam int PIX_W  = 8;
  localparam int TS_W   = 7;
  localparam int DIM_W  = 12;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = 12;
  localparam int TIN_W  = $clog2(MAX_TILE);
  localparam int SUM_W  = PIX_W + 2 * TIN_W;
  localparam int CNT_W  = 2 * TIN_W + 1;
  localparam int Q_W    = 8;
  localparam int STEP_W = $clog2(Q_W);
  localparam int CFG_AW = 2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_TILE_SIZE    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // configuration reset values
  localparam logic [TS_W-1:0]  TILE_SIZE_RST    = 7'd10;
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sums_t;

  typedef struct packed {
    logic [COL_W-1:0] tile_col;
    logic [ROW_W-1:0] tile_row;
    logic             end_of_frame;
  } tile_info_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // one restoring division step: quotient bit on top, new remainder below
  function automatic logic [SUM_W:0] div_step(input logic [SUM_W-1:0] rem,
                                              input logic [SUM_W-1:0] dsr);
    logic [SUM_W:0] res;
    if (rem >= dsr) res = {1'b1, rem - dsr};
    else            res = {1'b0, rem};
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/tap_sum_ram.sv =====
// per tile column channel sums, one entry for each tile column
// single write port, single registered read port; uses tap_pkg
`default_nettype none

module tap_sum_ram (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [tap_pkg::COL_W-1:0] waddr,
  input  wire tap_pkg::sums_t          wdata,
  input  wire logic                    re,
  input  wire logic [tap_pkg::COL_W-1:0] raddr,
  output tap_pkg::sums_t               rdata
);

  tap_pkg::sums_t mem [tap_pkg::MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/tap_divider.sv =====
// iterative divider for the three channel sums of a finished tile, with output register
// one quotient bit per cycle for all channels; uses tap_pkg
`default_nettype none

module tap_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire tap_pkg::sums_t            sums,
  input  wire logic [tap_pkg::CNT_W-1:0] count,
  input  wire tap_pkg::tile_info_t       info,
  output logic                           busy,
  output logic                           tile_valid,
  input  wire logic                      tile_stall,
  output tap_pkg::tile_info_t            tile_info,
  output logic [tap_pkg::PIX_W-1:0]      avg_blue,
  output logic [tap_pkg::PIX_W-1:0]      avg_green,
  output logic [tap_pkg::PIX_W-1:0]      avg_red
);

  localparam logic [tap_pkg::STEP_W-1:0] STEP_LAST = tap_pkg::STEP_W'(tap_pkg::Q_W - 1);

  tap_pkg::div_state_t state, state_next;
  logic [tap_pkg::STEP_W-1:0] step;
  tap_pkg::sums_t rem;
  logic [tap_pkg::SUM_W-1:0] dsr;
  logic [tap_pkg::Q_W-1:0] quo_b, quo_g, quo_r;
  tap_pkg::tile_info_t info_hold;
  logic out_load;
  logic [tap_pkg::SUM_W:0] st_b, st_g, st_r;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tap_pkg::DIV_IDLE: if (load) state_next = tap_pkg::DIV_RUN;
      tap_pkg::DIV_RUN:  if (step == STEP_LAST) state_next = tap_pkg::DIV_DONE;
      tap_pkg::DIV_DONE: if (!tile_valid || !tile_stall) state_next = tap_pkg::DIV_IDLE;
      default:           state_next = tap_pkg::DIV_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy     = 1'b0;
    out_load = 1'b0;
    unique case (state)
      tap_pkg::DIV_IDLE: busy = 1'b0;
      tap_pkg::DIV_RUN:  busy = 1'b1;
      tap_pkg::DIV_DONE: begin
        busy     = 1'b1;
        out_load = !tile_valid || !tile_stall;
      end
      default:           busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tap_pkg::DIV_IDLE;
    else     state <= state_next;
  end

  // one subtract step per channel
  assign st_b = tap_pkg::div_step(rem.blue, dsr);
  assign st_g = tap_pkg::div_step(rem.green, dsr);
  assign st_r = tap_pkg::div_step(rem.red, dsr);

  // iteration datapath
  always_ff @(posedge clk) begin
    if (state == tap_pkg::DIV_IDLE && load) begin
      rem       <= sums;
      dsr       <= {count, {(tap_pkg::Q_W - 1){1'b0}}};
      step      <= '0;
      info_hold <= info;
    end else if (state == tap_pkg::DIV_RUN) begin
      rem.blue  <= st_b[tap_pkg::SUM_W-1:0];
      rem.green <= st_g[tap_pkg::SUM_W-1:0];
      rem.red   <= st_r[tap_pkg::SUM_W-1:0];
      quo_b     <= {quo_b[tap_pkg::Q_W-2:0], st_b[tap_pkg::SUM_W]};
      quo_g     <= {quo_g[tap_pkg::Q_W-2:0], st_g[tap_pkg::SUM_W]};
      quo_r     <= {quo_r[tap_pkg::Q_W-2:0], st_r[tap_pkg::SUM_W]};
      dsr       <= dsr >> 1;
      step      <= step + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      tile_info <= info_hold;
      avg_blue  <= quo_b;
      avg_green <= quo_g;
      avg_red   <= quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)             tile_valid <= 1'b0;
    else if (out_load)   tile_valid <= 1'b1;
    else if (!tile_stall) tile_valid <= 1'b0;
  end

endmodule

`default_nettype wire

// ===== design/tile_average_pixelate.sv =====
// Block-average mosaic over a BGR pixel stream in raster order.
// Pixel channel: pixel_valid / pixel_stall with blue, green, red, frame_start.
// An item is taken at a clock edge where pixel_valid is high and pixel_stall low.
// frame_start puts the position to row 0, column 0 before that pixel is used.
// Tile channel: tile_valid / tile_stall with tile_col, tile_row, the three
// averages and end_of_frame; one item per finished tile, end_of_frame on the last.
// Config: cfg_wen, cfg_addr, cfg_data; 0 tile_size, 1 image_width, 2 image_height.
// Any register write also restarts the frame position.
// Pixel flow: a pixel that does not close a tile causes no stall of its own. A
// pixel that closes a tile stalls the pixel channel until it has passed the sum
// update stage, the bit-serial divider and the load of the output register, and
// until the divider has gone idle again. The divider sets this.
// A stalled tile item holds; the finished next tile waits in the divider and
// pixels stall until the output register frees.
// Reset (rst, synchronous) clears position and handshake state and loads the
// register defaults 10, 640, 480; the column sum memory needs no clearing.
// Depends on tap_pkg, tap_sum_ram, tap_divider, tile_average_pixelate_defines.svh.
`default_nettype none
`include "tile_average_pixelate_defines.svh"

module tile_average_pixelate (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [tap_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [tap_pkg::DIM_W-1:0]  cfg_data,
  input  wire logic                       pixel_valid,
  output logic                            pixel_stall,
  input  wire logic [tap_pkg::PIX_W-1:0]  blue,
  input  wire logic [tap_pkg::PIX_W-1:0]  green,
  input  wire logic [tap_pkg::PIX_W-1:0]  red,
  input  wire logic                       frame_start,
  output logic                            tile_valid,
  input  wire logic                       tile_stall,
  output logic [tap_pkg::COL_W-1:0]       tile_col,
  output logic [tap_pkg::ROW_W-1:0]       tile_row,
  output logic [tap_pkg::PIX_W-1:0]       avg_blue,
  output logic [tap_pkg::PIX_W-1:0]       avg_green,
  output logic [tap_pkg::PIX_W-1:0]       avg_red,
  output logic                            end_of_frame
);

  localparam int TS_MAX = tap_pkg::MAX_TILE;
  localparam int W_MAX  = tap_pkg::MAX_WIDTH;

  // configuration
  logic [tap_pkg::TS_W-1:0]  tile_size;
  logic [tap_pkg::DIM_W-1:0] image_width;
  logic [tap_pkg::DIM_W-1:0] image_height;

  // position counters
  logic [tap_pkg::COL_W-1:0] pixel_column;
  logic [tap_pkg::ROW_W-1:0] pixel_row;
  logic [tap_pkg::TIN_W-1:0] column_in_tile;
  logic [tap_pkg::TIN_W-1:0] row_in_tile;
  logic [tap_pkg::COL_W-1:0] tile_x;
  logic [tap_pkg::ROW_W-1:0] tile_y;

  logic [tap_pkg::TS_W-1:0]  t_eff, t_last;
  logic [tap_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [tap_pkg::COL_W-1:0] cur_col, cur_tx;
  logic [tap_pkg::ROW_W-1:0] cur_row, cur_ty;
  logic [tap_pkg::TIN_W-1:0] cur_cit, cur_rit;
  logic last_col, last_row, cit_end, rit_end, emit, first;
  logic [2*tap_pkg::TS_W-1:0] count_full;
  logic accept;

  // update stage
  logic                      s1_valid;
  logic                      s1_emit;
  logic                      s1_first;
  logic                      s1_fwd;
  logic [tap_pkg::COL_W-1:0] s1_addr;
  logic [tap_pkg::PIX_W-1:0] s1_b, s1_g, s1_r;
  logic [tap_pkg::CNT_W-1:0] s1_count;
  tap_pkg::tile_info_t       s1_info;
  tap_pkg::sums_t            fwd_sums;
  tap_pkg::sums_t            rd_sums, base_sums, new_sums;
  tap_pkg::tile_info_t       out_info;
  logic                      div_busy;

  // clamped configuration
  always_comb begin
    if (tile_size == '0)                         t_eff = tap_pkg::TS_W'(1);
    else if (tile_size > tap_pkg::TS_W'(TS_MAX)) t_eff = tap_pkg::TS_W'(TS_MAX);
    else                                         t_eff = tile_size;
    if (image_width == '0)                          w_eff = tap_pkg::DIM_W'(1);
    else if (image_width > tap_pkg::DIM_W'(W_MAX))  w_eff = tap_pkg::DIM_W'(W_MAX);
    else                                            w_eff = image_width;
    if (image_height == '0) h_eff = tap_pkg::DIM_W'(1);
    else                    h_eff = image_height;
    t_last = t_eff - 1'b1;
  end

  // current position, frame start forces the origin
  always_comb begin
    cur_col = frame_start ? '0 : pixel_column;
    cur_row = frame_start ? '0 : pixel_row;
    cur_cit = frame_start ? '0 : column_in_tile;
    cur_rit = frame_start ? '0 : row_in_tile;
    cur_tx  = frame_start ? '0 : tile_x;
    cur_ty  = frame_start ? '0 : tile_y;
    last_col = {1'b0, cur_col} == (w_eff - 1'b1);
    last_row = cur_row == (h_eff - 1'b1);
    cit_end  = {1'b0, cur_cit} == t_last;
    rit_end  = {1'b0, cur_rit} == t_last;
    emit     = (last_col || cit_end) && (last_row || rit_end);
    first    = (cur_cit == '0) && (cur_rit == '0);
    count_full = ({1'b0, cur_cit} + 1'b1) * ({1'b0, cur_rit} + 1'b1);
  end

  assign pixel_stall = (s1_valid && s1_emit) || div_busy;
  assign accept      = pixel_valid && !pixel_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size    <= tap_pkg::TILE_SIZE_RST;
      image_width  <= tap_pkg::IMAGE_WIDTH_RST;
      image_height <= tap_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        tap_pkg::CFG_TILE_SIZE:    tile_size    <= cfg_data[tap_pkg::TS_W-1:0];
        tap_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        tap_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position and tile indexes
  always_ff @(posedge clk) begin
    if (rst || (cfg_wen && (cfg_addr == tap_pkg::CFG_TILE_SIZE ||
                            cfg_addr == tap_pkg::CFG_IMAGE_WIDTH ||
                            cfg_addr == tap_pkg::CFG_IMAGE_HEIGHT))) begin
      pixel_column   <= '0;
      pixel_row      <= '0;
      column_in_tile <= '0;
      row_in_tile    <= '0;
      tile_x         <= '0;
      tile_y         <= '0;
    end else if (accept) begin
      if (last_col) begin
        pixel_column   <= '0;
        column_in_tile <= '0;
        tile_x         <= '0;
        if (last_row) begin
          pixel_row   <= '0;
          row_in_tile <= '0;
          tile_y      <= '0;
        end else begin
          pixel_row <= cur_row + 1'b1;
          if (rit_end) begin
            row_in_tile <= '0;
            tile_y      <= cur_ty + 1'b1;
          end else begin
            row_in_tile <= cur_rit + 1'b1;
            tile_y      <= cur_ty;
          end
        end
      end else begin
        pixel_column <= cur_col + 1'b1;
        pixel_row    <= cur_row;
        row_in_tile  <= cur_rit;
        tile_y       <= cur_ty;
        if (cit_end) begin
          column_in_tile <= '0;
          tile_x         <= cur_tx + 1'b1;
        end else begin
          column_in_tile <= cur_cit + 1'b1;
          tile_x         <= cur_tx;
        end
      end
    end
  end

  // column sum memory, read at accept, written back from the update stage
  tap_sum_ram u_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (new_sums),
    .re    (accept),
    .raddr (cur_tx),
    .rdata (rd_sums)
  );

  // update stage control
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= accept;
  end

  // update stage payload, forward the write that the memory read missed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit  <= emit;
      s1_first <= first;
      s1_addr  <= cur_tx;
      s1_b     <= blue;
      s1_g     <= green;
      s1_r     <= red;
      s1_count <= count_full[tap_pkg::CNT_W-1:0];
      s1_info  <= '{tile_col: cur_tx, tile_row: cur_ty,
                    end_of_frame: last_col && last_row};
      s1_fwd   <= s1_valid && (s1_addr == cur_tx);
      fwd_sums <= new_sums;
    end
  end

  // accumulate, the first pixel of a tile overwrites the entry
  always_comb begin
    base_sums = s1_fwd ? fwd_sums : rd_sums;
    if (s1_first) begin
      new_sums.blue  = tap_pkg::SUM_W'(s1_b);
      new_sums.green = tap_pkg::SUM_W'(s1_g);
      new_sums.red   = tap_pkg::SUM_W'(s1_r);
    end else begin
      new_sums.blue  = base_sums.blue  + tap_pkg::SUM_W'(s1_b);
      new_sums.green = base_sums.green + tap_pkg::SUM_W'(s1_g);
      new_sums.red   = base_sums.red   + tap_pkg::SUM_W'(s1_r);
    end
  end

  tap_divider u_div (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_valid && s1_emit),
    .sums       (new_sums),
    .count      (s1_count),
    .info       (s1_info),
    .busy       (div_busy),
    .tile_valid (tile_valid),
    .tile_stall (tile_stall),
    .tile_info  (out_info),
    .avg_blue   (avg_blue),
    .avg_green  (avg_green),
    .avg_red    (avg_red)
  );

  assign tile_col     = out_info.tile_col;
  assign tile_row     = out_info.tile_row;
  assign end_of_frame = out_info.end_of_frame;

  // checks
  `TAP_ASSERT_NEXT(a_emit_starts_div, s1_valid && s1_emit, div_busy,
                   "finished tile did not start the divider")
  `TAP_ASSERT_NOW(a_div_done_output, $fell(div_busy), tile_valid,
                  "divider went idle without presenting an item")
  `TAP_ASSERT_NOW(a_position_in_range, 1'b1,
                  ({1'b0, pixel_column} < w_eff) && ({1'b0, column_in_tile} < t_eff)
                  && (row_in_tile < t_eff[tap_pkg::TIN_W:0]),
                  "position counters left the image or tile")

endmodule

`default_nettype wire
